// ===== rtl/core/aramo_pkg.sv =====
// Package: shared types and constants for the atomic reservation unit.
`timescale 1ns / 1ps

package aramo_pkg;

  typedef enum logic [1:0] {
    REQ_WRITE = 2'd0,
    REQ_LR    = 2'd1,
    REQ_SC    = 2'd2,
    REQ_AMO   = 2'd3
  } req_type_e;

  typedef enum logic [3:0] {
    AMO_SWAP = 4'd0,
    AMO_ADD  = 4'd1,
    AMO_XOR  = 4'd2,
    AMO_AND  = 4'd3,
    AMO_OR   = 4'd4,
    AMO_MIN  = 4'd5,
    AMO_MAX  = 4'd6,
    AMO_MINU = 4'd7,
    AMO_MAXU = 4'd8
  } amo_op_e;

  typedef enum logic [1:0] {
    FAULT_NONE      = 2'd0,
    FAULT_MISALIGN  = 2'd1,
    FAULT_UNMAPPED  = 2'd2,
    FAULT_DEV_ERROR = 2'd3
  } fault_e;

  localparam int unsigned DataW = 64;
  localparam int unsigned WordW = 32;

  localparam logic [DataW-1:0] WordMask = {{(DataW-WordW){1'b0}}, {WordW{1'b1}}};

endpackage

// ===== rtl/core/aramo_alu.sv =====
// AMO read-modify-write datapath: computes the replacement value.
`timescale 1ns / 1ps

module aramo_alu import aramo_pkg::*; (
  input  logic [3:0]       op_i,
  input  logic [DataW-1:0] mem_i,     // original value, already width-masked
  input  logic [DataW-1:0] opnd_i,    // operand, already width-masked
  input  logic             dbl_i,
  output logic [DataW-1:0] res_o
);

  logic [DataW-1:0] sbit;
  logic [DataW-1:0] mask;
  logic [DataW-1:0] sum;
  logic             slt;
  logic             ult;

  always_comb begin
    sbit = dbl_i ? {1'b1, {(DataW-1){1'b0}}} : {{(DataW-WordW){1'b0}}, 1'b1, {(WordW-1){1'b0}}};
    mask = dbl_i ? {DataW{1'b1}} : WordMask;
    // signed compare by flipping the sign bit of the active width
    slt  = ((mem_i ^ sbit) & mask) < ((opnd_i ^ sbit) & mask);
    ult  = mem_i < opnd_i;
    sum  = (mem_i + opnd_i) & mask;
    case (op_i)
      AMO_SWAP: res_o = opnd_i;
      AMO_ADD:  res_o = sum;
      AMO_XOR:  res_o = mem_i ^ opnd_i;
      AMO_AND:  res_o = mem_i & opnd_i;
      AMO_OR:   res_o = mem_i | opnd_i;
      AMO_MIN:  res_o = slt ? mem_i : opnd_i;
      AMO_MAX:  res_o = slt ? opnd_i : mem_i;
      AMO_MINU: res_o = ult ? mem_i : opnd_i;
      AMO_MAXU: res_o = ult ? opnd_i : mem_i;
      default:  res_o = mem_i;  // undefined op writes the original back
    endcase
  end

endmodule

// ===== rtl/core/atomic_reservation_amo_unit_core.sv =====
// Top level: LR/SC reservations, AMO and plain-write control for all harts.
// Pipeline: a word accepted is registered in the input register, resolved in the compute stage,
// and its result is registered in the result register, which drives done_o and the result outputs.
// Throughput: one word per cycle; busy_o stays low, the receiver cannot stall.
// Reservation state is resolved in the single compute stage between the two registers.
// Reset: pipeline valids and all reservation valid bits clear; stored addresses are not reset.
`timescale 1ns / 1ps

module atomic_reservation_amo_unit_core import aramo_pkg::*; #(
  parameter int unsigned HARTS     = 4,
  parameter int unsigned ADDR_BITS = 32
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             start_i,
  output logic             busy_o,
  input  logic [1:0]       req_type_i,
  input  logic [1:0]       hart_id_i,
  input  logic [31:0]      address_i,
  input  logic             is_double_i,
  input  logic [3:0]       amo_op_i,
  input  logic [DataW-1:0] operand_i,
  input  logic [DataW-1:0] mem_data_i,
  input  logic             unmapped_i,
  input  logic             read_error_i,
  input  logic             write_error_i,
  output logic             done_o,
  output logic [1:0]       fault_o,
  output logic             sc_success_o,
  output logic             write_enable_o,
  output logic [DataW-1:0] write_data_o,
  output logic [DataW-1:0] result_value_o
);

  localparam int unsigned IdxW = (HARTS > 1) ? $clog2(HARTS) : 1;
  localparam int unsigned ExtW = (IdxW > 2) ? IdxW : 2;
  localparam int unsigned AW   = (ADDR_BITS < 32) ? ADDR_BITS : 32;

  typedef struct packed {
    logic [AW-1:0] addr;
    logic          dbl;
  } resv_ent_t;

  // input register
  logic             in_vld_q;
  req_type_e        req_q;
  logic [IdxW-1:0]  slot_q;
  logic             has_slot_q;
  logic [AW-1:0]    addr_q;
  logic             dbl_q;
  logic [3:0]       op_q;
  logic [DataW-1:0] opnd_q;
  logic [DataW-1:0] mdata_q;
  logic             unmapped_q;
  logic             rerr_q;
  logic             werr_q;

  // reservation storage
  logic [HARTS-1:0] resv_vld_q, resv_vld_d;
  resv_ent_t        resv_mem [HARTS];
  resv_ent_t        resv_rd_q;

  // compute stage
  logic [ExtW-1:0]  hart_ext;
  logic [IdxW-1:0]  slot_in;
  logic             accept;
  logic [DataW-1:0] dmask;
  logic [DataW-1:0] opnd_m;
  logic [DataW-1:0] mdata_m;
  logic [DataW-1:0] amo_res;
  logic             misal;
  logic             sel_vld;
  logic             match;
  logic             lr_set;
  logic             sc_drop;
  logic             clr_all;
  fault_e           fault_d;
  logic             sc_ok_d;
  logic             wen_d;
  logic [DataW-1:0] wdata_d;
  logic [DataW-1:0] result_d;

  // result register
  logic             done_q;
  fault_e           fault_q;
  logic             sc_ok_q;
  logic             wen_q;
  logic [DataW-1:0] wdata_q;
  logic [DataW-1:0] result_q;

  assign busy_o   = 1'b0;
  assign accept   = start_i & ~busy_o;
  assign hart_ext = ExtW'(hart_id_i);
  assign slot_in  = hart_ext[IdxW-1:0];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q <= 1'b0;
    end else begin
      in_vld_q <= accept;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      req_q      <= req_type_e'(req_type_i);
      slot_q     <= slot_in;
      has_slot_q <= ({30'b0, hart_id_i} < 32'(HARTS));
      addr_q     <= address_i[AW-1:0];
      dbl_q      <= is_double_i;
      op_q       <= amo_op_i;
      opnd_q     <= operand_i;
      mdata_q    <= mem_data_i;
      unmapped_q <= unmapped_i;
      rerr_q     <= read_error_i;
      werr_q     <= write_error_i;
    end
  end

  // Reservation table: written by a completing LR, read for the incoming word.
  // A same-slot write at the read edge is forwarded.
  always_ff @(posedge clk_i) begin
    if (lr_set) begin
      resv_mem[slot_q] <= '{addr: addr_q, dbl: dbl_q};
    end
    if (lr_set && (slot_q == slot_in)) begin
      resv_rd_q <= '{addr: addr_q, dbl: dbl_q};
    end else begin
      resv_rd_q <= resv_mem[slot_in];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      resv_vld_q <= '0;
    end else begin
      resv_vld_q <= resv_vld_d;
    end
  end

  assign dmask   = dbl_q ? {DataW{1'b1}} : WordMask;
  assign opnd_m  = opnd_q & dmask;
  assign mdata_m = mdata_q & dmask;

  aramo_alu u_alu (
    .op_i   (op_q),
    .mem_i  (mdata_m),
    .opnd_i (opnd_m),
    .dbl_i  (dbl_q),
    .res_o  (amo_res)
  );

  always_comb begin
    misal    = (req_q != REQ_WRITE) && (dbl_q ? (addr_q[2:0] != 3'b0) : (addr_q[1:0] != 2'b0));
    sel_vld  = has_slot_q ? resv_vld_q[slot_q] : 1'b0;
    match    = sel_vld && (resv_rd_q.addr == addr_q) && (resv_rd_q.dbl == dbl_q);
    fault_d  = FAULT_NONE;
    sc_ok_d  = 1'b0;
    wen_d    = 1'b0;
    wdata_d  = '0;
    result_d = '0;
    lr_set   = 1'b0;
    sc_drop  = 1'b0;
    clr_all  = 1'b0;

    if (in_vld_q) begin
      if (misal) begin
        fault_d = FAULT_MISALIGN;
      end else begin
        unique case (req_q)
          REQ_WRITE: begin
            if (unmapped_q) begin
              fault_d = FAULT_UNMAPPED;
            end else begin
              wen_d   = 1'b1;
              wdata_d = opnd_m;
              if (werr_q) fault_d = FAULT_DEV_ERROR;
              else        clr_all = 1'b1;
            end
          end
          REQ_LR: begin
            if (unmapped_q) begin
              fault_d = FAULT_UNMAPPED;
            end else if (rerr_q) begin
              fault_d = FAULT_DEV_ERROR;
            end else begin
              result_d = mdata_m;
              lr_set   = has_slot_q;
            end
          end
          REQ_SC: begin
            sc_drop = has_slot_q;
            if (unmapped_q) begin
              fault_d = FAULT_UNMAPPED;
            end else if (match) begin
              wen_d   = 1'b1;
              wdata_d = opnd_m;
              if (werr_q) begin
                fault_d = FAULT_DEV_ERROR;
              end else begin
                sc_ok_d = 1'b1;
                clr_all = 1'b1;
              end
            end
          end
          REQ_AMO: begin
            if (unmapped_q) begin
              fault_d = FAULT_UNMAPPED;
            end else if (rerr_q) begin
              fault_d = FAULT_DEV_ERROR;
            end else begin
              result_d = mdata_m;
              wen_d    = 1'b1;
              wdata_d  = amo_res & dmask;
              if (werr_q) fault_d = FAULT_DEV_ERROR;
              else        clr_all = 1'b1;
            end
          end
          default: fault_d = FAULT_NONE;
        endcase
      end
    end

    resv_vld_d = resv_vld_q;
    if (sc_drop) resv_vld_d[slot_q] = 1'b0;
    if (lr_set)  resv_vld_d[slot_q] = 1'b1;
    if (clr_all) resv_vld_d = '0;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      done_q <= 1'b0;
    end else begin
      done_q <= in_vld_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_vld_q) begin
      fault_q  <= fault_d;
      sc_ok_q  <= sc_ok_d;
      wen_q    <= wen_d;
      wdata_q  <= wdata_d;
      result_q <= result_d;
    end
  end

  assign done_o         = done_q;
  assign fault_o        = fault_q;
  assign sc_success_o   = sc_ok_q;
  assign write_enable_o = wen_q;
  assign write_data_o   = wdata_q;
  assign result_value_o = result_q;

endmodule
